// ===== design/gbaqi_pkg.sv =====
// Shared types, constants and codes for the gas-baseline air-quality index core.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package gbaqi_pkg;

   // Fixed-point formats
   localparam int GAS_BITS        = 26;
   localparam int BASE_FRAC_BITS  = 8;
   localparam int RATIO_FRAC_BITS = 12;
   localparam int WEIGHT_BITS     = 16;
   localparam int BASE_BITS       = GAS_BITS + BASE_FRAC_BITS;
   localparam int PROD_BITS       = WEIGHT_BITS + BASE_BITS;
   localparam int RATIO_BITS      = RATIO_FRAC_BITS + 2;
   localparam int TEMP_BITS       = 12;
   localparam int HUM_BITS        = 11;
   localparam int IDX_BITS        = 9;
   localparam int IDX_SUM_BITS    = IDX_BITS + 1;
   localparam int PEN_BITS        = 10;
   localparam int STEP_BITS       = $clog2(RATIO_FRAC_BITS);

   // Index and penalty thresholds (temperature and humidity in 1/16 units)
   localparam int HUM_LOW    = 35 * 16;
   localparam int HUM_HIGH   = 65 * 16;
   localparam int TEMP_LOW   = 18 * 16;
   localparam int TEMP_HIGH  = 30 * 16;
   localparam int IDX_MIN    = 25;
   localparam int IDX_MAX    = 500;
   localparam int IDX_MID    = 100;
   localparam int DROP_SLOPE = 125;
   localparam int RISE_SLOPE = 500;
   localparam int DROP_CAP   = 75;
   localparam int RISE_CAP   = 400;

   // Configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = GAS_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WARMUP    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAST_W    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOW_W    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW_LIMIT = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH_LIM  = 3'd4;

   localparam logic [7:0]             WARMUP_RST    = 8'd120;
   localparam logic [WEIGHT_BITS-1:0] FAST_W_RST    = 16'd6554;
   localparam logic [WEIGHT_BITS-1:0] SLOW_W_RST    = 16'd1311;
   localparam logic [GAS_BITS-1:0]    LOW_LIM_RST   = 26'd1000;
   localparam logic [GAS_BITS-1:0]    HIGH_LIM_RST  = 26'd5000000;

   // Reading class codes
   localparam logic [1:0] CLASS_NORMAL = 2'd0;
   localparam logic [1:0] CLASS_FAULT  = 2'd1;
   localparam logic [1:0] CLASS_CLEAN  = 2'd2;

   typedef struct packed {
      logic [GAS_BITS-1:0]         gas_resistance;
      logic signed [TEMP_BITS-1:0] temperature;
      logic [HUM_BITS-1:0]         humidity;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] air_index;
      logic                valid_res;
      logic [1:0]          reading_class;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PREP,
      ST_MUL,
      ST_UPDATE,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_MAP,
      ST_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic ld_req;
      logic check;
      logic prep;
      logic mul;
      logic update;
      logic div_init;
      logic div_step;
      logic map;
      logic ld_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic special;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/gas_baseline_air_quality_index_core.sv =====
// Gas-baseline air-quality index core: one request in, one index response out.
// A fault or clean reading goes from the check straight to the output; any other
// reading also passes the baseline multiply and the ratio divider, one bit per cycle
// (13 quotient bits). No request is taken until the last response is loaded; a finished
// response waits in its register while the next request is taken. Synchronous active-high
// reset restores register defaults and clears the baseline (unseeded) and sample count.
`default_nettype none

module gas_baseline_air_quality_index_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire gbaqi_pkg::req_type                  req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output gbaqi_pkg::rsp_type                       rsp_payload,
   input  wire logic                                csr_we,
   input  wire logic [gbaqi_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [gbaqi_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import gbaqi_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   gbaqi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and state
   gbaqi_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== design/gbaqi_ctrl.sv =====
// Sequencer for the air-quality index core: steps one request through the datapath.
// Depends on gbaqi_pkg for the state, command and status types.
`default_nettype none

module gbaqi_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire gbaqi_pkg::sts_type sts,
   output gbaqi_pkg::cmd_type     cmd
);
   import gbaqi_pkg::*;

   state_type              state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_CHECK;
         ST_CHECK:    state_in = sts.special ? ST_OUT : ST_PREP;
         ST_PREP:     state_in = ST_MUL;
         ST_MUL:      state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV_STEP;
         ST_DIV_STEP: begin
            if (step_ff == STEP_BITS'(RATIO_FRAC_BITS - 1)) state_in = ST_MAP;
         end
         ST_MAP:      state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Commands and handshake
   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      step_in      = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.ld_req = req_valid;
         end
         ST_CHECK:    cmd.check  = 1'b1;
         ST_PREP:     cmd.prep   = 1'b1;
         ST_MUL:      cmd.mul    = 1'b1;
         ST_UPDATE:   cmd.update = 1'b1;
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
         end
         ST_MAP:      cmd.map    = 1'b1;
         ST_OUT:      cmd.ld_rsp = out_free;
         default:     ;
      endcase
   end

   // Hold the response until taken
   always_comb begin
      priority if (cmd.ld_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/gbaqi_dpath.sv =====
// Datapath: configuration registers, baseline average, ratio divider, index mapping.
// Depends on gbaqi_pkg; driven by gbaqi_ctrl commands.
`default_nettype none

module gbaqi_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [gbaqi_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [gbaqi_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  wire gbaqi_pkg::req_type                  req_payload,
   input  wire gbaqi_pkg::cmd_type                  cmd,
   output gbaqi_pkg::sts_type                       sts,
   output gbaqi_pkg::rsp_type                       rsp_payload
);
   import gbaqi_pkg::*;

   localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << RATIO_FRAC_BITS;
   localparam logic [RATIO_BITS-1:0] RATIO_TWO = RATIO_BITS'(2) << RATIO_FRAC_BITS;

   // Configuration
   logic [7:0]             warmup_ff;
   logic [WEIGHT_BITS-1:0] fast_w_ff, slow_w_ff;
   logic [GAS_BITS-1:0]    low_lim_ff, high_lim_ff;

   // Request and per-request working registers
   req_type                req_ff;
   logic [1:0]             class_ff;
   logic                   vld_ff;
   logic [IDX_BITS-1:0]    idx_ff;
   logic [PEN_BITS-1:0]    pen_ff;
   logic                   down_ff;
   logic [BASE_BITS-1:0]   diff_ff;
   logic [WEIGHT_BITS-1:0] w_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [BASE_BITS-1:0]   rem_ff;
   logic [RATIO_BITS-1:0]  quo_ff;
   logic                   sat_ff;
   rsp_type                rsp_ff;

   // Persistent state
   logic [BASE_BITS-1:0]   base_ff, base_in;
   logic [7:0]             seen_ff, seen_in;

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff   <= WARMUP_RST;
         fast_w_ff   <= FAST_W_RST;
         slow_w_ff   <= SLOW_W_RST;
         low_lim_ff  <= LOW_LIM_RST;
         high_lim_ff <= HIGH_LIM_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WARMUP:    warmup_ff   <= csr_wdata[7:0];
            CSR_FAST_W:    fast_w_ff   <= csr_wdata[WEIGHT_BITS-1:0];
            CSR_SLOW_W:    slow_w_ff   <= csr_wdata[WEIGHT_BITS-1:0];
            CSR_LOW_LIMIT: low_lim_ff  <= csr_wdata[GAS_BITS-1:0];
            CSR_HIGH_LIM:  high_lim_ff <= csr_wdata[GAS_BITS-1:0];
            default:       ;
         endcase
      end
   end

   // Classify the sample
   logic is_fault, is_clean;
   assign is_fault    = req_ff.gas_resistance <= low_lim_ff;
   assign is_clean    = req_ff.gas_resistance > high_lim_ff;
   assign sts.special = is_fault || is_clean;

   // Humidity and temperature penalty, in 1/16 units
   logic [HUM_BITS-1:0]         hum_pen;
   logic signed [TEMP_BITS:0]   t_ext, t_lo_d, t_hi_d;
   logic [TEMP_BITS-1:0]        temp_pen;
   logic [TEMP_BITS:0]          pen_sum;

   always_comb begin
      hum_pen = '0;
      if (req_ff.humidity < HUM_BITS'(HUM_LOW)) begin
         hum_pen = HUM_BITS'(HUM_LOW) - req_ff.humidity;
      end else if (req_ff.humidity > HUM_BITS'(HUM_HIGH)) begin
         hum_pen = req_ff.humidity - HUM_BITS'(HUM_HIGH);
      end
      t_ext    = (TEMP_BITS+1)'(req_ff.temperature);
      t_lo_d   = (TEMP_BITS+1)'(TEMP_LOW) - t_ext;
      t_hi_d   = t_ext - (TEMP_BITS+1)'(TEMP_HIGH);
      temp_pen = '0;
      if (t_lo_d > 0) begin
         temp_pen = t_lo_d[TEMP_BITS-1:0];
      end else if (t_hi_d > 0) begin
         temp_pen = t_hi_d[TEMP_BITS-1:0];
      end
      pen_sum = (TEMP_BITS+1)'(hum_pen) + (TEMP_BITS+1)'(temp_pen);
   end

   // Seed, weight select and distance to the baseline
   logic [BASE_BITS-1:0] gfix, seeded;
   assign gfix   = BASE_BITS'(req_ff.gas_resistance) << BASE_FRAC_BITS;
   assign seeded = (base_ff == '0) ? gfix : base_ff;

   // Baseline step: floor going up, ceiling going down
   logic [PROD_BITS-1:0] step_up_full;
   logic [PROD_BITS:0]   prod_rnd, step_dn_full;
   assign step_up_full = prod_ff >> WEIGHT_BITS;
   assign prod_rnd     = (PROD_BITS+1)'(prod_ff) + (PROD_BITS+1)'((1 << WEIGHT_BITS) - 1);
   assign step_dn_full = prod_rnd >> WEIGHT_BITS;

   always_comb begin
      base_in = base_ff;
      seen_in = seen_ff;
      if (cmd.prep) begin
         base_in = seeded;
      end else if (cmd.update) begin
         base_in = down_ff ? base_ff - step_dn_full[BASE_BITS-1:0]
                           : base_ff + step_up_full[BASE_BITS-1:0];
         if (seen_ff != 8'hFF) seen_in = seen_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         seen_ff <= '0;
      end else begin
         base_ff <= base_in;
         seen_ff <= seen_in;
      end
   end

   // Restoring divider: gfix / baseline, one quotient bit per step
   logic [BASE_BITS-1:0] den;
   logic [BASE_BITS:0]   rem_sh, rem_sub;
   logic                 rem_ge;
   assign den     = (base_ff == '0) ? BASE_BITS'(1) : base_ff;
   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_ge  = rem_sh >= {1'b0, den};
   assign rem_sub = rem_sh - {1'b0, den};

   // Ratio to index
   logic [RATIO_BITS-1:0]    ratio, off_hi, off_lo;
   logic [RATIO_BITS+6:0]    drop_x;
   logic [RATIO_BITS+8:0]    rise_x;
   logic [RATIO_BITS+6:0]    drop_full;
   logic [RATIO_BITS+8:0]    rise_full;
   logic [IDX_BITS-1:0]      idx_base;
   logic [IDX_SUM_BITS-1:0]  idx_sum;
   logic [IDX_BITS-1:0]      idx_final;

   always_comb begin
      ratio     = sat_ff ? RATIO_TWO : quo_ff;
      off_hi    = ratio - RATIO_ONE;
      off_lo    = RATIO_ONE - ratio;
      drop_x    = (RATIO_BITS+7)'(off_hi) * (RATIO_BITS+7)'(DROP_SLOPE);
      rise_x    = (RATIO_BITS+9)'(off_lo) * (RATIO_BITS+9)'(RISE_SLOPE);
      drop_full = (drop_x + (RATIO_BITS+7)'(RATIO_ONE - 1'b1)) >> RATIO_FRAC_BITS;
      rise_full = rise_x >> RATIO_FRAC_BITS;
      if (ratio >= RATIO_ONE) begin
         idx_base = (drop_full > (RATIO_BITS+7)'(DROP_CAP))
                    ? IDX_BITS'(IDX_MID - DROP_CAP)
                    : IDX_BITS'(IDX_MID) - drop_full[IDX_BITS-1:0];
      end else begin
         idx_base = (rise_full > (RATIO_BITS+9)'(RISE_CAP))
                    ? IDX_BITS'(IDX_MID + RISE_CAP)
                    : IDX_BITS'(IDX_MID) + rise_full[IDX_BITS-1:0];
      end
      idx_sum   = IDX_SUM_BITS'(idx_base) + IDX_SUM_BITS'(pen_ff);
      idx_final = (idx_sum > IDX_SUM_BITS'(IDX_MAX)) ? IDX_BITS'(IDX_MAX)
                                                     : idx_sum[IDX_BITS-1:0];
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.ld_req) req_ff <= req_payload;
      if (cmd.check) begin
         vld_ff <= req_ff.gas_resistance != '0;
         pen_ff <= PEN_BITS'(pen_sum >> 3);
         priority if (is_fault) begin
            class_ff <= CLASS_FAULT;
            idx_ff   <= IDX_BITS'(IDX_MAX);
         end else if (is_clean) begin
            class_ff <= CLASS_CLEAN;
            idx_ff   <= IDX_BITS'(IDX_MIN);
         end else begin
            class_ff <= CLASS_NORMAL;
         end
      end
      if (cmd.prep) begin
         down_ff <= gfix < seeded;
         diff_ff <= (gfix < seeded) ? seeded - gfix : gfix - seeded;
         w_ff    <= (seen_ff < warmup_ff) ? fast_w_ff : slow_w_ff;
      end
      if (cmd.mul) prod_ff <= PROD_BITS'(w_ff) * PROD_BITS'(diff_ff);
      if (cmd.div_init) begin
         sat_ff <= {1'b0, gfix} >= {den, 1'b0};
         rem_ff <= (gfix >= den) ? gfix - den : gfix;
         quo_ff <= RATIO_BITS'(gfix >= den);
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_sub[BASE_BITS-1:0] : rem_sh[BASE_BITS-1:0];
         quo_ff <= {quo_ff[RATIO_BITS-2:0], rem_ge};
      end
      if (cmd.map) idx_ff <= idx_final;
      if (cmd.ld_rsp) begin
         rsp_ff.air_index     <= idx_ff;
         rsp_ff.valid_res     <= vld_ff;
         rsp_ff.reading_class <= class_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
